/* sv/ppi_pkg.sv */
// ---------------------------------------------------------------------------
// ppi_pkg : shared types, constants and functions for the pose integrator
// Fixed-point widths, register and action codes, CORDIC arctangent table,
// clamp and saturation helpers.
// ---------------------------------------------------------------------------
package ppi_pkg;

    // CORDIC iteration count and table depth
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 30;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    // field widths
    localparam int VEL_W  = 24;
    localparam int DT_W   = 24;
    localparam int POS_W  = 32;
    localparam int HEAD_W = 31;
    localparam int LIM_W  = 23;

    // internal datapath widths
    localparam int ANG_W   = 34;                // Q4.30 angle and CORDIC x/y
    localparam int VPROD_W = VEL_W + ANG_W;     // v * trig
    localparam int RATE_W  = VPROD_W - 16;      // rounded rate, Q.30
    localparam int DPROD_W = RATE_W + DT_W;     // rate * dt
    localparam int WPROD_W = VEL_W + DT_W + 1;  // w * dt
    localparam int DPOS_W  = DPROD_W - 38;      // position delta
    localparam int DHEAD_W = WPROD_W - 12;      // heading delta
    localparam int WRAP_W  = 39;                // heading before wrap
    localparam int WRAP_STEPS = 6;              // restoring steps, 2pi*32 .. 2pi

    localparam int CNT_MAX = (CORDIC_ITERS > VEL_W) ? CORDIC_ITERS : VEL_W;
    localparam int CNT_W   = $clog2(CNT_MAX);

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // angle constants
    localparam logic signed [WRAP_W-1:0] PI_Q28     = 39'sd843314857;
    localparam logic signed [WRAP_W-1:0] TWO_PI_Q28 = 39'sd1686629713;
    localparam logic signed [ANG_W-1:0]  PI_Q30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0]  CORDIC_GAIN = 34'sd652032874;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIVE_MODE     = 3'd0,
        REG_SPEED_LIMIT    = 3'd1,
        REG_YAW_RATE_LIMIT = 3'd2,
        REG_INIT_X         = 3'd3,
        REG_INIT_Y         = 3'd4,
        REG_INIT_HEADING   = 3'd5
    } cfg_reg_t;

    // action codes
    typedef enum logic [1:0] {
        ACT_CMD  = 2'd0,
        ACT_TICK = 2'd1,
        ACT_LOAD = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    // arctangent of 2^-i, Q4.30
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            CNT_W'(0): r = 34'sd843314857;
            CNT_W'(1): r = 34'sd497837829;
            CNT_W'(2): r = 34'sd263043837;
            CNT_W'(3): r = 34'sd133525159;
            CNT_W'(4): r = 34'sd67021687;
            CNT_W'(5): r = 34'sd33543516;
            CNT_W'(6): r = 34'sd16775851;
            CNT_W'(7): r = 34'sd8388437;
            CNT_W'(8): r = 34'sd4194283;
            CNT_W'(9): r = 34'sd2097149;
            // past index 9 the table is an exact power of two
            default: r = (idx < CNT_W'(ATAN_ENTRIES))
                         ? (34'sd1 <<< (CNT_W'(ATAN_ENTRIES) - idx)) : '0;
        endcase
        return r;
    endfunction

    // symmetric clamp of a velocity to [-lim, lim]
    function automatic logic signed [VEL_W-1:0] clamp_vel(
        input logic signed [VEL_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [VEL_W:0] l;
        logic signed [VEL_W:0] nl;
        logic signed [VEL_W:0] vw;
        logic signed [VEL_W-1:0] r;
        l  = $signed({2'b00, lim});
        nl = -l;
        vw = (VEL_W+1)'(v);
        if (vw > l)
            r = l[VEL_W-1:0];
        else if (vw < nl)
            r = nl[VEL_W-1:0];
        else
            r = v;
        return r;
    endfunction

    // saturate a grown position sum to 32 bits
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] s);
        logic signed [POS_W-1:0] r;
        if (s[POS_W+1:POS_W-1] == 3'b000 || s[POS_W+1:POS_W-1] == 3'b111)
            r = s[POS_W-1:0];
        else if (s[POS_W+1])
            r = {1'b1, {(POS_W-1){1'b0}}};
        else
            r = {1'b0, {(POS_W-1){1'b1}}};
        return r;
    endfunction

endpackage

/* sv/ppi_if.sv */
// ---------------------------------------------------------------------------
// ppi_if : input and output channels of the pose integrator
// Valid/ready channels carrying one action word and one pose word.
// ---------------------------------------------------------------------------
interface ppi_in_if;
    import ppi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [VEL_W-1:0]  cmd_vel_x;
    logic signed [VEL_W-1:0]  cmd_vel_y;
    logic signed [VEL_W-1:0]  cmd_yaw_rate;
    logic [DT_W-1:0]          tick_dt;

    modport source (
        output valid, action, cmd_vel_x, cmd_vel_y, cmd_yaw_rate, tick_dt,
        input  ready
    );
    modport sink (
        input  valid, action, cmd_vel_x, cmd_vel_y, cmd_yaw_rate, tick_dt,
        output ready
    );
endinterface

interface ppi_out_if;
    import ppi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pose_x;
    logic signed [POS_W-1:0]  pose_y;
    logic signed [HEAD_W-1:0] pose_heading;
    logic signed [VEL_W-1:0]  out_vel_x;
    logic signed [VEL_W-1:0]  out_vel_y;
    logic signed [VEL_W-1:0]  out_yaw_rate;

    modport source (
        output valid, pose_x, pose_y, pose_heading, out_vel_x, out_vel_y, out_yaw_rate,
        input  ready
    );
    modport sink (
        input  valid, pose_x, pose_y, pose_heading, out_vel_x, out_vel_y, out_yaw_rate,
        output ready
    );
endinterface

/* sv/planar_pose_integrator.sv */
// ---------------------------------------------------------------------------
// planar_pose_integrator : fixed-point Euler pose integrator
// Holds clamped velocity commands, integrates pose on ticks with a
// one-step-per-cycle CORDIC and bit-serial multipliers, loads initial pose.
// ---------------------------------------------------------------------------
//  channel   | dir | word
//  ----------+-----+---------------------------------------------------------
//  in_chan   | in  | action, cmd_vel_x, cmd_vel_y, cmd_yaw_rate, tick_dt
//  out_chan  | out | pose_x, pose_y, pose_heading, out_vel_x/y, out_yaw_rate
//  cfg_*     | in  | write enable, register index, write data
//
//  One word at a time. A command goes on to the output stage; a load
//  runs the heading wrap on the initial heading. A tick runs one CORDIC
//  step per cycle, then one multiplier bit per cycle for v*trig and for
//  rate*dt and w*dt, then six restoring steps of the 2pi heading wrap.
//  in_chan.ready is high whenever no word is in work; a finished word waits
//  in the output register while the next word is taken.
//  rst_n clears pose, held and applied velocities and restores the registers.
// ---------------------------------------------------------------------------
module planar_pose_integrator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ppi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppi_pkg::CFG_W-1:0]     cfg_data,
    ppi_in_if.sink                        in_chan,
    ppi_out_if.source                     out_chan
);
    import ppi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CORDIC = 6'b000010,
        S_VMUL   = 6'b000100,
        S_DMUL   = 6'b001000,
        S_WRAP   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    // configuration registers
    logic                      drive_mode_reg;
    logic [LIM_W-1:0]          speed_limit_reg;
    logic [LIM_W-1:0]          yaw_rate_limit_reg;
    logic signed [POS_W-1:0]   init_x_reg;
    logic signed [POS_W-1:0]   init_y_reg;
    logic signed [HEAD_W-1:0]  init_heading_reg;

    // control and architectural state
    state_t                    state_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [POS_W-1:0]   pos_x_reg;
    logic signed [POS_W-1:0]   pos_y_reg;
    logic signed [HEAD_W-1:0]  heading_reg;
    logic signed [VEL_W-1:0]   held_vel_x_reg;
    logic signed [VEL_W-1:0]   held_vel_y_reg;
    logic signed [VEL_W-1:0]   held_yaw_rate_reg;
    logic signed [VEL_W-1:0]   applied_vel_x_reg;
    logic signed [VEL_W-1:0]   applied_vel_y_reg;
    logic signed [VEL_W-1:0]   applied_yaw_rate_reg;
    logic                      out_valid_reg;

    // datapath work registers
    logic signed [ANG_W-1:0]   cx_reg;
    logic signed [ANG_W-1:0]   cy_reg;
    logic signed [ANG_W-1:0]   cz_reg;
    logic                      flip_reg;
    logic [VEL_W-1:0]          vx_sh_reg;
    logic [VEL_W-1:0]          vy_sh_reg;
    logic [DT_W-1:0]           dt_sh_reg;
    logic signed [VPROD_W-1:0] mc_reg;
    logic signed [VPROD_W-1:0] ms_reg;
    logic signed [VPROD_W-1:0] accx_reg;
    logic signed [VPROD_W-1:0] accy_reg;
    logic signed [DPROD_W-1:0] dmx_reg;
    logic signed [DPROD_W-1:0] dmy_reg;
    logic signed [DPROD_W-1:0] daccx_reg;
    logic signed [DPROD_W-1:0] daccy_reg;
    logic signed [WPROD_W-1:0] wm_reg;
    logic signed [WPROD_W-1:0] wacc_reg;
    logic signed [WRAP_W-1:0]  wrap_reg;

    // output word
    logic signed [POS_W-1:0]   o_pose_x_reg;
    logic signed [POS_W-1:0]   o_pose_y_reg;
    logic signed [HEAD_W-1:0]  o_heading_reg;
    logic signed [VEL_W-1:0]   o_vel_x_reg;
    logic signed [VEL_W-1:0]   o_vel_y_reg;
    logic signed [VEL_W-1:0]   o_yaw_rate_reg;

    logic in_accept;
    logic out_load;
    logic cordic_last, vmul_last, dmul_last, wrap_last;

    assign in_chan.ready = (state_reg == S_IDLE);
    assign in_accept     = in_chan.valid && (state_reg == S_IDLE);
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || out_chan.ready);

    assign cordic_last = (cnt_reg == CNT_W'(CORDIC_ITERS - 1));
    assign vmul_last   = (cnt_reg == CNT_W'(VEL_W - 1));
    assign dmul_last   = (cnt_reg == CNT_W'(DT_W - 1));
    assign wrap_last   = (cnt_reg == CNT_W'(WRAP_STEPS));

    // CORDIC start angle: move by pi outside +-pi/2
    logic signed [ANG_W-1:0] z_raw, z_start;
    logic                    flip_start;
    always_comb
    begin
        z_raw = ANG_W'(heading_reg) <<< 2;
        if (z_raw > HALF_PI_Q30)
        begin
            z_start    = z_raw - PI_Q30;
            flip_start = 1'b1;
        end
        else if (z_raw < -HALF_PI_Q30)
        begin
            z_start    = z_raw + PI_Q30;
            flip_start = 1'b1;
        end
        else
        begin
            z_start    = z_raw;
            flip_start = 1'b0;
        end
    end

    // one CORDIC rotation step
    logic signed [ANG_W-1:0] xsh, ysh, cx_next, cy_next, cz_next, atan_val;
    always_comb
    begin
        xsh      = cx_reg >>> cnt_reg;
        ysh      = cy_reg >>> cnt_reg;
        atan_val = atan_q30(cnt_reg);
        if (!cz_reg[ANG_W-1])
        begin
            cx_next = cx_reg - ysh;
            cy_next = cy_reg + xsh;
            cz_next = cz_reg - atan_val;
        end
        else
        begin
            cx_next = cx_reg + ysh;
            cy_next = cy_reg - xsh;
            cz_next = cz_reg + atan_val;
        end
    end

    // cosine and sine as first multiplicands
    logic signed [ANG_W-1:0] cos_val, sin_val;
    assign cos_val = flip_reg ? -cx_next : cx_next;
    assign sin_val = flip_reg ? -cy_next : cy_next;

    // v * trig, one velocity bit per cycle; the sign bit has negative weight
    logic signed [VPROD_W-1:0] pxc, pxs, pyc, pys, accx_next, accy_next;
    logic signed [VPROD_W-1:0] rndx, rndy;
    logic signed [RATE_W-1:0]  rate_x, rate_y;
    always_comb
    begin
        pxc = vx_sh_reg[0] ? mc_reg : '0;
        pxs = vx_sh_reg[0] ? ms_reg : '0;
        pyc = vy_sh_reg[0] ? mc_reg : '0;
        pys = vy_sh_reg[0] ? ms_reg : '0;
        if (vmul_last)
        begin
            accx_next = accx_reg - pxc + pys;
            accy_next = accy_reg - pxs - pyc;
        end
        else
        begin
            accx_next = accx_reg + pxc - pys;
            accy_next = accy_reg + pxs + pyc;
        end
        rndx   = accx_next + (VPROD_W'(1) <<< 15);
        rndy   = accy_next + (VPROD_W'(1) <<< 15);
        rate_x = rndx[VPROD_W-1:16];
        rate_y = rndy[VPROD_W-1:16];
    end

    // rate * dt and w * dt, one dt bit per cycle
    logic signed [DPROD_W-1:0] daccx_next, daccy_next, rdx, rdy;
    logic signed [WPROD_W-1:0] wacc_next, rdw;
    logic signed [DPOS_W-1:0]  dpos_x, dpos_y;
    logic signed [DHEAD_W-1:0] dhead;
    logic signed [POS_W-1:0]   pos_x_next, pos_y_next;
    logic signed [WRAP_W-1:0]  wrap_start;
    always_comb
    begin
        daccx_next = daccx_reg + (dt_sh_reg[0] ? dmx_reg : '0);
        daccy_next = daccy_reg + (dt_sh_reg[0] ? dmy_reg : '0);
        wacc_next  = wacc_reg + (dt_sh_reg[0] ? wm_reg : '0);
        rdx        = daccx_next + (DPROD_W'(1) <<< 37);
        rdy        = daccy_next + (DPROD_W'(1) <<< 37);
        rdw        = wacc_next + (WPROD_W'(1) <<< 11);
        dpos_x     = rdx[DPROD_W-1:38];
        dpos_y     = rdy[DPROD_W-1:38];
        dhead      = rdw[WPROD_W-1:12];
        pos_x_next = sat_pos((POS_W+2)'(pos_x_reg) + (POS_W+2)'(dpos_x));
        pos_y_next = sat_pos((POS_W+2)'(pos_y_reg) + (POS_W+2)'(dpos_y));
        wrap_start = WRAP_W'(heading_reg) + WRAP_W'(dhead) + PI_Q28;
    end

    // heading wrap: lift negatives by 2pi*32, then restoring subtract
    logic signed [WRAP_W-1:0] wrap_sub, wrap_next, head_full;
    always_comb
    begin
        wrap_sub = TWO_PI_Q28 <<< (CNT_W'(WRAP_STEPS) - cnt_reg);
        if (cnt_reg == '0)
            wrap_next = wrap_reg[WRAP_W-1] ? (wrap_reg + (TWO_PI_Q28 <<< 5)) : wrap_reg;
        else if (wrap_reg >= wrap_sub)
            wrap_next = wrap_reg - wrap_sub;
        else
            wrap_next = wrap_reg;
        head_full = wrap_next - PI_Q28;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_mode_reg     <= 1'b1;
            speed_limit_reg    <= '1;
            yaw_rate_limit_reg <= '1;
            init_x_reg         <= '0;
            init_y_reg         <= '0;
            init_heading_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DRIVE_MODE:     drive_mode_reg     <= cfg_data[0];
                REG_SPEED_LIMIT:    speed_limit_reg    <= cfg_data[LIM_W-1:0];
                REG_YAW_RATE_LIMIT: yaw_rate_limit_reg <= cfg_data[LIM_W-1:0];
                REG_INIT_X:         init_x_reg         <= cfg_data[POS_W-1:0];
                REG_INIT_Y:         init_y_reg         <= cfg_data[POS_W-1:0];
                REG_INIT_HEADING:   init_heading_reg   <= cfg_data[HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            cnt_reg              <= '0;
            pos_x_reg            <= '0;
            pos_y_reg            <= '0;
            heading_reg          <= '0;
            held_vel_x_reg       <= '0;
            held_vel_y_reg       <= '0;
            held_yaw_rate_reg    <= '0;
            applied_vel_x_reg    <= '0;
            applied_vel_y_reg    <= '0;
            applied_yaw_rate_reg <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_chan.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_accept)
                    begin
                        case (in_chan.action)
                            ACT_CMD:
                            begin
                                held_vel_x_reg    <= clamp_vel(in_chan.cmd_vel_x, speed_limit_reg);
                                held_vel_y_reg    <= clamp_vel(in_chan.cmd_vel_y, speed_limit_reg);
                                held_yaw_rate_reg <= clamp_vel(in_chan.cmd_yaw_rate,
                                                               yaw_rate_limit_reg);
                                state_reg         <= S_DONE;
                            end
                            ACT_TICK: state_reg <= S_CORDIC;
                            ACT_LOAD:
                            begin
                                pos_x_reg            <= init_x_reg;
                                pos_y_reg            <= init_y_reg;
                                applied_vel_x_reg    <= '0;
                                applied_vel_y_reg    <= '0;
                                applied_yaw_rate_reg <= '0;
                                state_reg            <= S_WRAP;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_CORDIC:
                begin
                    cnt_reg <= cordic_last ? '0 : cnt_reg + 1'b1;
                    if (cordic_last)
                        state_reg <= S_VMUL;
                end
                S_VMUL:
                begin
                    cnt_reg <= vmul_last ? '0 : cnt_reg + 1'b1;
                    if (vmul_last)
                        state_reg <= S_DMUL;
                end
                S_DMUL:
                begin
                    cnt_reg <= dmul_last ? '0 : cnt_reg + 1'b1;
                    if (dmul_last)
                    begin
                        pos_x_reg            <= pos_x_next;
                        pos_y_reg            <= pos_y_next;
                        applied_vel_x_reg    <= drive_mode_reg
                                                ? clamp_vel(held_vel_x_reg, speed_limit_reg)
                                                : held_vel_x_reg;
                        applied_vel_y_reg    <= drive_mode_reg ? '0 : held_vel_y_reg;
                        applied_yaw_rate_reg <= held_yaw_rate_reg;
                        state_reg            <= S_WRAP;
                    end
                end
                S_WRAP:
                begin
                    cnt_reg <= wrap_last ? '0 : cnt_reg + 1'b1;
                    if (wrap_last)
                    begin
                        heading_reg <= head_full[HEAD_W-1:0];
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath work registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cx_reg    <= CORDIC_GAIN;
                cy_reg    <= '0;
                cz_reg    <= z_start;
                flip_reg  <= flip_start;
                vx_sh_reg <= held_vel_x_reg;
                vy_sh_reg <= drive_mode_reg ? '0 : held_vel_y_reg;
                dt_sh_reg <= in_chan.tick_dt;
                wrap_reg  <= WRAP_W'(init_heading_reg) + PI_Q28;
            end
            S_CORDIC:
            begin
                cx_reg   <= cx_next;
                cy_reg   <= cy_next;
                cz_reg   <= cz_next;
                mc_reg   <= VPROD_W'(cos_val);
                ms_reg   <= VPROD_W'(sin_val);
                accx_reg <= '0;
                accy_reg <= '0;
            end
            S_VMUL:
            begin
                accx_reg  <= accx_next;
                accy_reg  <= accy_next;
                mc_reg    <= mc_reg <<< 1;
                ms_reg    <= ms_reg <<< 1;
                vx_sh_reg <= vx_sh_reg >> 1;
                vy_sh_reg <= vy_sh_reg >> 1;
                dmx_reg   <= DPROD_W'(rate_x);
                dmy_reg   <= DPROD_W'(rate_y);
                wm_reg    <= WPROD_W'(held_yaw_rate_reg);
                daccx_reg <= '0;
                daccy_reg <= '0;
                wacc_reg  <= '0;
            end
            S_DMUL:
            begin
                daccx_reg <= daccx_next;
                daccy_reg <= daccy_next;
                wacc_reg  <= wacc_next;
                dmx_reg   <= dmx_reg <<< 1;
                dmy_reg   <= dmy_reg <<< 1;
                wm_reg    <= wm_reg <<< 1;
                dt_sh_reg <= dt_sh_reg >> 1;
                wrap_reg  <= wrap_start;
            end
            S_WRAP:
            begin
                wrap_reg <= wrap_next;
            end
            default: ;
        endcase

        // output word
        if (out_load)
        begin
            o_pose_x_reg   <= pos_x_reg;
            o_pose_y_reg   <= pos_y_reg;
            o_heading_reg  <= heading_reg;
            o_vel_x_reg    <= applied_vel_x_reg;
            o_vel_y_reg    <= applied_vel_y_reg;
            o_yaw_rate_reg <= applied_yaw_rate_reg;
        end
    end

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.pose_x       = o_pose_x_reg;
    assign out_chan.pose_y       = o_pose_y_reg;
    assign out_chan.pose_heading = o_heading_reg;
    assign out_chan.out_vel_x    = o_vel_x_reg;
    assign out_chan.out_vel_y    = o_vel_y_reg;
    assign out_chan.out_yaw_rate = o_yaw_rate_reg;

endmodule

/* sv/ppi_checker.sv */
// ---------------------------------------------------------------------------
// ppi_checker : port-level checks for the pose integrator
// Watches the channel handshakes and the heading range on the output word.
// ---------------------------------------------------------------------------
module ppi_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [ppi_pkg::HEAD_W-1:0] pose_heading
);
    import ppi_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again before the word finished");

    // a new result is only loaded while no input is being taken
    a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a word in work");

    // heading on the output stays wrapped
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pose_heading >= -31'sd843314857) && (pose_heading <= 31'sd843314856))
        else $error("heading out of range");

endmodule

bind planar_pose_integrator ppi_checker u_ppi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .pose_heading (out_chan.pose_heading)
);
